// File: src/hga_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hga_pkg: shared types and constants
// Widths, defaults, sequencer states and the store request type used by the
// gated histogram accumulator.
// ----------------------------------------------------------------------------
package hga_pkg;

    // Default geometry of the histogram store.
    localparam int SPECTRA_DEF = 8;
    localparam int BINS_DEF    = 32768;

    // Field widths.
    localparam int SORT_W  = 16;
    localparam int GATE_W  = 8;
    localparam int BIN_W   = 16;
    localparam int SCALE_W = 16;
    localparam int CNT_W   = 32;
    localparam int PROD_W  = SORT_W + SCALE_W;
    localparam int FRAC_W  = 8;
    localparam int SBIN_W  = PROD_W - FRAC_W;

    // Widest flat store index: 255 * 65536 + 65535 fits in 24 bits.
    localparam int IDX_W = 24;

    // Scale factor after reset is 1.0 in 8.8 fixed point.
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    // Item kinds.
    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_WRITE
    } t_state;

    // One access to the counter store.
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
        logic [CNT_W-1:0] wr_data;
    } t_mem_req;

endpackage
`default_nettype wire

// File: src/hga_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hga_ifs: stream channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface hga_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [hga_pkg::SORT_W-1:0] sort_value;
    logic [hga_pkg::GATE_W-1:0] gate_value;
    logic [hga_pkg::GATE_W-1:0] read_spectrum;
    logic [hga_pkg::BIN_W-1:0]  read_bin;

    modport source (output valid, action, sort_value, gate_value, read_spectrum,
                    read_bin, input ready);
    modport sink (input valid, action, sort_value, gate_value, read_spectrum,
                  read_bin, output ready);
endinterface

interface hga_out_if;
    logic                      valid;
    logic                      ready;
    logic [hga_pkg::CNT_W-1:0] bin_count;
    logic                      event_counted;

    modport source (output valid, bin_count, event_counted, input ready);
    modport sink (input valid, bin_count, event_counted, output ready);
endinterface
`default_nettype wire

// File: src/hga_bin_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hga_bin_map: item to store index
// Scales the sort value, range-checks the spectrum and bin and forms the
// flat counter index, one register stage after the multiplier.
// ----------------------------------------------------------------------------
module hga_bin_map #(
    parameter int SPECTRA = hga_pkg::SPECTRA_DEF,
    parameter int BINS    = hga_pkg::BINS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_load,
    input  wire logic                        i_action,
    input  wire logic [hga_pkg::SORT_W-1:0]  i_sort_value,
    input  wire logic [hga_pkg::GATE_W-1:0]  i_gate_value,
    input  wire logic [hga_pkg::GATE_W-1:0]  i_read_spectrum,
    input  wire logic [hga_pkg::BIN_W-1:0]   i_read_bin,
    input  wire logic [hga_pkg::SCALE_W-1:0] i_scale,
    output logic                             o_action,
    output logic                             o_hit,
    output logic [hga_pkg::IDX_W-1:0]        o_addr
);

    logic                        r_action;
    logic [hga_pkg::PROD_W-1:0]  r_prod;
    logic [hga_pkg::GATE_W-1:0]  r_gate;
    logic [hga_pkg::GATE_W-1:0]  r_rspec;
    logic [hga_pkg::BIN_W-1:0]   r_rbin;
    logic                        r_hit;
    logic [hga_pkg::IDX_W-1:0]   r_addr;

    logic [hga_pkg::SBIN_W-1:0]  scaled_bin;
    logic [hga_pkg::GATE_W-1:0]  spec_sel;
    logic [hga_pkg::IDX_W-1:0]   bin_sel;
    logic                        spec_ok;
    logic                        bin_ok;
    logic                        n_hit;
    logic [hga_pkg::IDX_W-1:0]   n_addr;

    // Capture the item and its scaled sort value when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_action <= i_action;
            r_prod   <= hga_pkg::PROD_W'(i_sort_value) * hga_pkg::PROD_W'(i_scale);
            r_gate   <= i_gate_value;
            r_rspec  <= i_read_spectrum;
            r_rbin   <= i_read_bin;
        end
    end

    // Pick spectrum and bin by item kind and check both against the geometry.
    always_comb begin
        scaled_bin = r_prod[hga_pkg::PROD_W-1:hga_pkg::FRAC_W];
        if (r_action == hga_pkg::ACT_READ) begin
            spec_sel = r_rspec;
            bin_sel  = {{(hga_pkg::IDX_W - hga_pkg::BIN_W){1'b0}}, r_rbin};
        end else begin
            spec_sel = r_gate;
            bin_sel  = scaled_bin;
        end
        spec_ok = {1'b0, spec_sel} < (hga_pkg::GATE_W + 1)'(SPECTRA);
        bin_ok  = bin_sel < hga_pkg::IDX_W'(BINS);
        n_hit   = spec_ok && bin_ok;
        n_addr  = {{(hga_pkg::IDX_W - hga_pkg::GATE_W){1'b0}}, spec_sel}
                  * hga_pkg::IDX_W'(BINS) + bin_sel;
    end

    // Index register feeding the store address.
    always_ff @(posedge i_clk) begin
        r_hit  <= n_hit;
        r_addr <= n_addr;
    end

    assign o_action = r_action;
    assign o_hit    = r_hit;
    assign o_addr   = r_addr;

endmodule
`default_nettype wire

// File: src/hga_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hga_store: counter memory
// Single-port counter memory with registered read data and a zeroing sweep
// after reset.
// ----------------------------------------------------------------------------
module hga_store #(
    parameter int SPECTRA = hga_pkg::SPECTRA_DEF,
    parameter int BINS    = hga_pkg::BINS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire hga_pkg::t_mem_req         i_req,
    output logic [hga_pkg::CNT_W-1:0]      o_rd_data,
    output logic                           o_busy
);

    localparam int DEPTH  = SPECTRA * BINS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [hga_pkg::CNT_W-1:0] r_mem [DEPTH];
    logic [hga_pkg::CNT_W-1:0] r_rd_data;
    logic                      r_clearing;
    logic [ADDR_W-1:0]         r_clr_addr;

    logic [ADDR_W-1:0]         wr_addr;
    logic [hga_pkg::CNT_W-1:0] wr_data;
    logic                      wr_en;

    // Zeroing sweep, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // The sweep owns the write port while it runs.
    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_req.wr_en;
            wr_addr = i_req.addr[ADDR_W-1:0];
            wr_data = i_req.wr_data;
        end
    end

    // Memory write.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr[ADDR_W-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

endmodule
`default_nettype wire

// File: src/gated_histogram_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gated_histogram_accumulator: gated multichannel histogram
// Counts events into per-gate spectra of 32-bit counters and returns and
// clears single counters on request.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                                           Transfer
//  i_in      in   action, sort_value, gate_value, read_spectrum,   valid & ready
//                 read_bin
//  o_out     out  bin_count, event_counted                         valid & ready
//  cfg       in   i_cfg_we, i_cfg_wdata (scale_factor)             write enable
//
//  Each item passes in turn through accept with multiply, index, memory read,
//  and write back, set by the single-port read-modify-write of the store.
//  After reset the store is zeroed one entry per cycle, SPECTRA * BINS entries
//  (262144 by default), with i_in.ready low; configuration writes still land.
//  A result waits in the output register; a new item is accepted meanwhile,
//  and write back stalls only while the previous result is still untaken.
// ----------------------------------------------------------------------------
module gated_histogram_accumulator #(
    parameter int SPECTRA = hga_pkg::SPECTRA_DEF,
    parameter int BINS    = hga_pkg::BINS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hga_pkg::SCALE_W-1:0] i_cfg_wdata,
    hga_in_if.sink                           i_in,
    hga_out_if.source                        o_out
);

    hga_pkg::t_state           r_state;
    hga_pkg::t_state           n_state;
    logic [hga_pkg::SCALE_W-1:0] r_scale;
    logic                      r_out_valid;
    logic [hga_pkg::CNT_W-1:0] r_out_count;
    logic                      r_out_counted;

    logic                      in_ready;
    logic                      load;
    logic                      out_load;
    logic                      out_free;
    logic [hga_pkg::CNT_W-1:0] n_out_count;
    logic                      n_out_counted;
    hga_pkg::t_mem_req         mem_req;

    logic                      map_action;
    logic                      map_hit;
    logic [hga_pkg::IDX_W-1:0] map_addr;
    logic [hga_pkg::CNT_W-1:0] rd_data;
    logic                      store_busy;

    // Scale factor register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= hga_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    hga_bin_map #(
        .SPECTRA (SPECTRA),
        .BINS    (BINS)
    ) u_bin_map (
        .i_clk           (i_clk),
        .i_load          (load),
        .i_action        (i_in.action),
        .i_sort_value    (i_in.sort_value),
        .i_gate_value    (i_in.gate_value),
        .i_read_spectrum (i_in.read_spectrum),
        .i_read_bin      (i_in.read_bin),
        .i_scale         (r_scale),
        .o_action        (map_action),
        .o_hit           (map_hit),
        .o_addr          (map_addr)
    );

    hga_store #(
        .SPECTRA (SPECTRA),
        .BINS    (BINS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data),
        .o_busy    (store_busy)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hga_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, store access and result forming.
    always_comb begin
        n_state         = r_state;
        in_ready        = 1'b0;
        out_load        = 1'b0;
        out_free        = !r_out_valid || o_out.ready;
        mem_req.rd_en   = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.addr    = map_addr;
        mem_req.wr_data = '0;
        n_out_count     = '0;
        n_out_counted   = 1'b0;
        if (map_action == hga_pkg::ACT_COUNT) begin
            mem_req.wr_data = rd_data + 1'b1;
            n_out_counted   = map_hit;
        end else if (map_hit) begin
            n_out_count = rd_data;
        end
        case (r_state)
            hga_pkg::ST_CLEAR: begin
                if (!store_busy) begin
                    n_state = hga_pkg::ST_IDLE;
                end
            end
            hga_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = hga_pkg::ST_ADDR;
                end
            end
            hga_pkg::ST_ADDR: begin
                n_state = hga_pkg::ST_READ;
            end
            hga_pkg::ST_READ: begin
                mem_req.rd_en = map_hit;
                n_state       = hga_pkg::ST_WRITE;
            end
            hga_pkg::ST_WRITE: begin
                if (out_free) begin
                    mem_req.wr_en = map_hit;
                    out_load      = 1'b1;
                    n_state       = hga_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hga_pkg::ST_IDLE;
            end
        endcase
    end

    assign load = in_ready && i_in.valid;

    // Output register: holds one result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count   <= n_out_count;
            r_out_counted <= n_out_counted;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.bin_count     = r_out_count;
    assign o_out.event_counted = r_out_counted;

endmodule
`default_nettype wire
